// ===== hdl/pcr_pkg.sv =====
package pcr_pkg;

  localparam int ARG_W   = 16;
  localparam int COORD_W = 32;
  localparam int NUM_ARGS = 6;

  // ascii command letters
  localparam logic [7:0] CH_UP_M = 8'h4D;
  localparam logic [7:0] CH_LO_M = 8'h6D;
  localparam logic [7:0] CH_UP_L = 8'h4C;
  localparam logic [7:0] CH_LO_L = 8'h6C;
  localparam logic [7:0] CH_UP_H = 8'h48;
  localparam logic [7:0] CH_LO_H = 8'h68;
  localparam logic [7:0] CH_UP_V = 8'h56;
  localparam logic [7:0] CH_LO_V = 8'h76;
  localparam logic [7:0] CH_UP_C = 8'h43;
  localparam logic [7:0] CH_LO_C = 8'h63;
  localparam logic [7:0] CH_UP_S = 8'h53;
  localparam logic [7:0] CH_LO_S = 8'h73;
  localparam logic [7:0] CH_UP_Q = 8'h51;
  localparam logic [7:0] CH_LO_Q = 8'h71;
  localparam logic [7:0] CH_UP_T = 8'h54;
  localparam logic [7:0] CH_LO_T = 8'h74;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_Z = 8'h7A;

  // bit that marks a lowercase (relative) letter
  localparam int REL_BIT = 5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MOVE,
    OP_LINE,
    OP_HORIZ,
    OP_VERT,
    OP_CUBIC,
    OP_SMOOTH_CUBIC,
    OP_QUAD,
    OP_SMOOTH_QUAD,
    OP_CLOSE
  } op_t;

  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_CUBIC = 3'd2,
    KIND_QUAD  = 3'd3,
    KIND_CLOSE = 3'd4,
    KIND_FILL  = 3'd5
  } kind_t;

  typedef struct packed {
    op_t                                op;
    logic                               rel;
    logic                               path_end;
    logic [NUM_ARGS-1:0][ARG_W-1:0]     arg;
  } entry_t;

endpackage

// ===== hdl/pcr_cmd_if.sv =====
interface pcr_cmd_if;
  logic               valid;
  logic               ready;
  logic [7:0]         action;
  logic signed [15:0] arg0;
  logic signed [15:0] arg1;
  logic signed [15:0] arg2;
  logic signed [15:0] arg3;
  logic signed [15:0] arg4;
  logic signed [15:0] arg5;
  logic               cmd_valid;
  logic               path_end;

  modport source (
    output valid, action, arg0, arg1, arg2, arg3, arg4, arg5, cmd_valid, path_end,
    input  ready
  );
  modport sink (
    input  valid, action, arg0, arg1, arg2, arg3, arg4, arg5, cmd_valid, path_end,
    output ready
  );
endinterface

// ===== hdl/pcr_prim_if.sv =====
interface pcr_prim_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] pt1_x;
  logic signed [31:0] pt1_y;
  logic signed [31:0] pt2_x;
  logic signed [31:0] pt2_y;
  logic signed [31:0] pt3_x;
  logic signed [31:0] pt3_y;
  logic               run_last;

  modport source (
    output valid, kind, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, run_last,
    input  ready
  );
  modport sink (
    input  valid, kind, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, run_last,
    output ready
  );
endinterface

// ===== hdl/pcr_front.sv =====
module pcr_front (
  pcr_cmd_if.sink          cmd,
  output logic             q_valid,
  input  logic             q_ready,
  output pcr_pkg::entry_t  q_entry
);

  pcr_pkg::op_t op;

  always_comb begin
    case (cmd.action)
      pcr_pkg::CH_UP_M, pcr_pkg::CH_LO_M: op = pcr_pkg::OP_MOVE;
      pcr_pkg::CH_UP_L, pcr_pkg::CH_LO_L: op = pcr_pkg::OP_LINE;
      pcr_pkg::CH_UP_H, pcr_pkg::CH_LO_H: op = pcr_pkg::OP_HORIZ;
      pcr_pkg::CH_UP_V, pcr_pkg::CH_LO_V: op = pcr_pkg::OP_VERT;
      pcr_pkg::CH_UP_C, pcr_pkg::CH_LO_C: op = pcr_pkg::OP_CUBIC;
      pcr_pkg::CH_UP_S, pcr_pkg::CH_LO_S: op = pcr_pkg::OP_SMOOTH_CUBIC;
      pcr_pkg::CH_UP_Q, pcr_pkg::CH_LO_Q: op = pcr_pkg::OP_QUAD;
      pcr_pkg::CH_UP_T, pcr_pkg::CH_LO_T: op = pcr_pkg::OP_SMOOTH_QUAD;
      pcr_pkg::CH_UP_Z, pcr_pkg::CH_LO_Z: op = pcr_pkg::OP_CLOSE;
      default:                            op = pcr_pkg::OP_NONE;
    endcase
    if (!cmd.cmd_valid) begin
      op = pcr_pkg::OP_NONE;
    end
  end

  always_comb begin
    q_entry.op       = op;
    q_entry.rel      = cmd.action[pcr_pkg::REL_BIT];
    q_entry.path_end = cmd.path_end;
    q_entry.arg[0]   = cmd.arg0;
    q_entry.arg[1]   = cmd.arg1;
    q_entry.arg[2]   = cmd.arg2;
    q_entry.arg[3]   = cmd.arg3;
    q_entry.arg[4]   = cmd.arg4;
    q_entry.arg[5]   = cmd.arg5;
  end

  // requests that produce nothing are taken and dropped here
  assign q_valid   = cmd.valid && ((op != pcr_pkg::OP_NONE) || cmd.path_end);
  assign cmd.ready = q_ready;

endmodule

// ===== hdl/pcr_queue.sv =====
module pcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcr_pkg::entry_t  in_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output pcr_pkg::entry_t  out_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pcr_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != FULL_CNT);
  assign out_valid = (count != '0);
  assign out_entry = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/pcr_back.sv =====
module pcr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  pcr_pkg::entry_t  q_entry,
  pcr_prim_if.source       prim
);

  typedef enum logic {
    PH_PRIM,
    PH_FILL
  } phase_t;

  phase_t             phase, phase_next;
  logic               out_valid;
  pcr_pkg::kind_t     kind, kind_next;
  logic signed [31:0] pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y;
  logic signed [31:0] pt1_x_next, pt1_y_next, pt2_x_next, pt2_y_next;
  logic signed [31:0] pt3_x_next, pt3_y_next;
  logic               run_last, run_last_next;

  logic signed [31:0] start_x, start_y, cur_x, cur_y, ctrl_x, ctrl_y;
  logic signed [31:0] start_x_next, start_y_next, cur_x_next, cur_y_next;
  logic signed [31:0] ctrl_x_next, ctrl_y_next;

  logic signed [31:0] base_x, base_y;
  logic signed [31:0] ax [3];
  logic signed [31:0] ay [3];
  logic signed [31:0] vy;
  logic signed [31:0] refl_x, refl_y;

  logic load;
  logic fire;
  logic has_prim;
  logic emit_fill;

  assign load      = !out_valid || prim.ready;
  assign fire      = load && q_valid;
  assign has_prim  = (q_entry.op != pcr_pkg::OP_NONE);
  assign emit_fill = q_entry.path_end && ((phase == PH_FILL) || !has_prim);
  // the entry leaves once its last result is loaded
  assign q_ready   = load && (emit_fill || !q_entry.path_end);

  assign base_x = q_entry.rel ? cur_x : '0;
  assign base_y = q_entry.rel ? cur_y : '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = 32'(signed'(q_entry.arg[2*i]))   + base_x;
      ay[i] = 32'(signed'(q_entry.arg[2*i+1])) + base_y;
    end
  end

  // vertical line takes its coordinate from the first argument
  assign vy     = 32'(signed'(q_entry.arg[0])) + base_y;
  assign refl_x = cur_x + cur_x - ctrl_x;
  assign refl_y = cur_y + cur_y - ctrl_y;

  always_comb begin
    kind_next     = pcr_pkg::KIND_FILL;
    pt1_x_next    = '0;
    pt1_y_next    = '0;
    pt2_x_next    = '0;
    pt2_y_next    = '0;
    pt3_x_next    = '0;
    pt3_y_next    = '0;
    run_last_next = 1'b1;
    phase_next    = PH_PRIM;
    start_x_next  = '0;
    start_y_next  = '0;
    cur_x_next    = '0;
    cur_y_next    = '0;
    ctrl_x_next   = '0;
    ctrl_y_next   = '0;
    if (!emit_fill) begin
      run_last_next = !q_entry.path_end;
      phase_next    = q_entry.path_end ? PH_FILL : PH_PRIM;
      start_x_next  = start_x;
      start_y_next  = start_y;
      cur_x_next    = cur_x;
      cur_y_next    = cur_y;
      ctrl_x_next   = ctrl_x;
      ctrl_y_next   = ctrl_y;
      case (q_entry.op)
        pcr_pkg::OP_MOVE: begin
          kind_next    = pcr_pkg::KIND_MOVE;
          pt1_x_next   = ax[0];
          pt1_y_next   = ay[0];
          start_x_next = ax[0];
          start_y_next = ay[0];
          cur_x_next   = ax[0];
          cur_y_next   = ay[0];
        end
        pcr_pkg::OP_LINE: begin
          kind_next  = pcr_pkg::KIND_LINE;
          pt1_x_next = ax[0];
          pt1_y_next = ay[0];
          cur_x_next = ax[0];
          cur_y_next = ay[0];
        end
        pcr_pkg::OP_HORIZ: begin
          kind_next  = pcr_pkg::KIND_LINE;
          pt1_x_next = ax[0];
          pt1_y_next = cur_y;
          cur_x_next = ax[0];
        end
        pcr_pkg::OP_VERT: begin
          kind_next  = pcr_pkg::KIND_LINE;
          pt1_x_next = cur_x;
          pt1_y_next = vy;
          cur_y_next = vy;
        end
        pcr_pkg::OP_CUBIC: begin
          kind_next   = pcr_pkg::KIND_CUBIC;
          pt1_x_next  = ax[0];
          pt1_y_next  = ay[0];
          pt2_x_next  = ax[1];
          pt2_y_next  = ay[1];
          pt3_x_next  = ax[2];
          pt3_y_next  = ay[2];
          ctrl_x_next = ax[1];
          ctrl_y_next = ay[1];
          cur_x_next  = ax[2];
          cur_y_next  = ay[2];
        end
        pcr_pkg::OP_SMOOTH_CUBIC: begin
          kind_next   = pcr_pkg::KIND_CUBIC;
          pt1_x_next  = refl_x;
          pt1_y_next  = refl_y;
          pt2_x_next  = ax[0];
          pt2_y_next  = ay[0];
          pt3_x_next  = ax[1];
          pt3_y_next  = ay[1];
          ctrl_x_next = ax[0];
          ctrl_y_next = ay[0];
          cur_x_next  = ax[1];
          cur_y_next  = ay[1];
        end
        pcr_pkg::OP_QUAD: begin
          kind_next   = pcr_pkg::KIND_QUAD;
          pt1_x_next  = ax[0];
          pt1_y_next  = ay[0];
          pt2_x_next  = ax[1];
          pt2_y_next  = ay[1];
          ctrl_x_next = ax[0];
          ctrl_y_next = ay[0];
          cur_x_next  = ax[1];
          cur_y_next  = ay[1];
        end
        pcr_pkg::OP_SMOOTH_QUAD: begin
          kind_next   = pcr_pkg::KIND_QUAD;
          pt1_x_next  = refl_x;
          pt1_y_next  = refl_y;
          pt2_x_next  = ax[0];
          pt2_y_next  = ay[0];
          ctrl_x_next = refl_x;
          ctrl_y_next = refl_y;
          cur_x_next  = ax[0];
          cur_y_next  = ay[0];
        end
        pcr_pkg::OP_CLOSE: begin
          kind_next  = pcr_pkg::KIND_CLOSE;
          pt1_x_next = start_x;
          pt1_y_next = start_y;
          cur_x_next = start_x;
          cur_y_next = start_y;
        end
        default: begin
          kind_next = pcr_pkg::KIND_FILL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= PH_PRIM;
      start_x   <= '0;
      start_y   <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
      ctrl_x    <= '0;
      ctrl_y    <= '0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        phase    <= phase_next;
        kind     <= kind_next;
        pt1_x    <= pt1_x_next;
        pt1_y    <= pt1_y_next;
        pt2_x    <= pt2_x_next;
        pt2_y    <= pt2_y_next;
        pt3_x    <= pt3_x_next;
        pt3_y    <= pt3_y_next;
        run_last <= run_last_next;
        start_x  <= start_x_next;
        start_y  <= start_y_next;
        cur_x    <= cur_x_next;
        cur_y    <= cur_y_next;
        ctrl_x   <= ctrl_x_next;
        ctrl_y   <= ctrl_y_next;
      end
    end
  end

  assign prim.valid    = out_valid;
  assign prim.kind     = kind;
  assign prim.pt1_x    = pt1_x;
  assign prim.pt1_y    = pt1_y;
  assign prim.pt2_x    = pt2_x;
  assign prim.pt2_y    = pt2_y;
  assign prim.pt3_x    = pt3_x;
  assign prim.pt3_y    = pt3_y;
  assign prim.run_last = run_last;

  a_fill_clears_state: assert property (@(posedge clk) disable iff (rst)
    (fire && emit_fill) |=> (start_x == 0 && start_y == 0 && cur_x == 0 &&
                             cur_y == 0 && ctrl_x == 0 && ctrl_y == 0))
    else $error("state not cleared after fill");

  a_fill_phase_has_entry: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FILL) |-> (q_valid && q_entry.path_end && has_prim))
    else $error("fill pending without its request at the queue head");

  a_fill_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == pcr_pkg::KIND_FILL) |-> run_last)
    else $error("fill result not marked last");

  a_fill_follows_prim: assert property (@(posedge clk) disable iff (rst)
    $rose(phase == PH_FILL) |-> (out_valid && !run_last))
    else $error("primitive before fill marked last");

endmodule

// ===== hdl/path_command_resolver.sv =====
// path_command_resolver: outline commands in, absolute drawing primitives out
// cmd channel: one request per command letter with six signed 16-bit args,
//   cmd_valid low skips it, path_end high closes the path with a fill
// prim channel: kind plus up to three 32-bit points and run_last, which
//   marks the last result caused by one request
// a decoder classifies each request into a small queue; the execution side
//   holds start, current and control points and feeds an output register
// throughput: one request per cycle while prim is ready; a request that
//   carries a primitive and path_end loads the primitive, then the fill
// a request passes the queue write, then the output register load, before
//   its first result appears on prim
// requests that produce no result are taken and dropped at the decoder
// a stalled prim channel holds the output register; the queue keeps taking
//   requests until QUEUE_DEPTH entries wait, then cmd.ready drops
// reset empties queue and output register, zeroes start, cur and ctrl points
module path_command_resolver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  pcr_cmd_if.sink     cmd,
  pcr_prim_if.source  prim
);

  logic            dec_valid;
  logic            dec_ready;
  pcr_pkg::entry_t dec_entry;
  logic            head_valid;
  logic            head_ready;
  pcr_pkg::entry_t head_entry;

  pcr_front u_front (
    .cmd     (cmd),
    .q_valid (dec_valid),
    .q_ready (dec_ready),
    .q_entry (dec_entry)
  );

  pcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_entry  (dec_entry),
    .out_valid (head_valid),
    .out_ready (head_ready),
    .out_entry (head_entry)
  );

  pcr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (head_valid),
    .q_ready (head_ready),
    .q_entry (head_entry),
    .prim    (prim)
  );

endmodule

// ===== test/tb_path_command_resolver.sv =====
module tb_path_command_resolver;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 6;
  // long run of full-size relative steps that carry the pen far outside the argument range
  localparam int RUN_STEPS    = 40;
  localparam logic [7:0] CH_UNKNOWN_A  = 8'h41;
  localparam logic [7:0] CH_UNKNOWN_FF = 8'hFF;
  localparam logic [7:0] DRAW_LETTERS [0:15] = '{
    pcr_pkg::CH_UP_L, pcr_pkg::CH_LO_L, pcr_pkg::CH_UP_H, pcr_pkg::CH_LO_H,
    pcr_pkg::CH_UP_V, pcr_pkg::CH_LO_V, pcr_pkg::CH_UP_C, pcr_pkg::CH_LO_C,
    pcr_pkg::CH_UP_S, pcr_pkg::CH_LO_S, pcr_pkg::CH_UP_Q, pcr_pkg::CH_LO_Q,
    pcr_pkg::CH_UP_T, pcr_pkg::CH_LO_T, pcr_pkg::CH_UP_Z, pcr_pkg::CH_LO_Z
  };

  typedef struct packed {
    logic [7:0]                                         action;
    logic [pcr_pkg::NUM_ARGS-1:0][pcr_pkg::ARG_W-1:0]   arg;
    logic                                               cmd_valid;
    logic                                               path_end;
  } outline_cmd_t;

  typedef struct packed {
    pcr_pkg::kind_t               kind;
    logic [pcr_pkg::COORD_W-1:0]  pt1_x;
    logic [pcr_pkg::COORD_W-1:0]  pt1_y;
    logic [pcr_pkg::COORD_W-1:0]  pt2_x;
    logic [pcr_pkg::COORD_W-1:0]  pt2_y;
    logic [pcr_pkg::COORD_W-1:0]  pt3_x;
    logic [pcr_pkg::COORD_W-1:0]  pt3_y;
    logic                         run_last;
  } primitive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcr_cmd_if  cmd_bus ();
  pcr_prim_if prim_bus ();

  path_command_resolver uut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_bus),
    .prim (prim_bus)
  );

  always #4 clk = ~clk;

  // pen state as the block should hold it
  logic [pcr_pkg::COORD_W-1:0] path_start_x, path_start_y;
  logic [pcr_pkg::COORD_W-1:0] pen_x, pen_y;
  logic [pcr_pkg::COORD_W-1:0] ctl_x, ctl_y;

  primitive_t pending_prims [$];
  int fail_count  = 0;
  int cycle_count = 0;
  int rx_hold     = 0;
  int rx_stall    = 0;
  bit tx_no_idle  = 1'b0;
  bit rx_no_idle  = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic primitive_t mk_prim(input pcr_pkg::kind_t k,
                                         input logic [pcr_pkg::COORD_W-1:0] x1, y1,
                                         x2, y2, x3, y3);
    primitive_t p;
    p.kind     = k;
    p.pt1_x    = x1;
    p.pt1_y    = y1;
    p.pt2_x    = x2;
    p.pt2_y    = y2;
    p.pt3_x    = x3;
    p.pt3_y    = y3;
    p.run_last = 1'b0;
    return p;
  endfunction

  function automatic void clear_pen();
    path_start_x = '0;
    path_start_y = '0;
    pen_x = '0;
    pen_y = '0;
    ctl_x = '0;
    ctl_y = '0;
  endfunction

  // absolute primitives that one accepted command should produce
  function automatic void resolve_command(input outline_cmd_t c);
    logic [pcr_pkg::COORD_W-1:0] a [pcr_pkg::NUM_ARGS];
    logic [pcr_pkg::COORD_W-1:0] px, py, rx, ry;
    primitive_t res [$];
    primitive_t tail;
    for (int i = 0; i < pcr_pkg::NUM_ARGS; i++)
      a[i] = {{(pcr_pkg::COORD_W-pcr_pkg::ARG_W){c.arg[i][pcr_pkg::ARG_W-1]}}, c.arg[i]};
    px = pen_x;
    py = pen_y;
    rx = px + px - ctl_x;
    ry = py + py - ctl_y;
    if (c.cmd_valid) begin
      case (c.action)
        pcr_pkg::CH_UP_M, pcr_pkg::CH_LO_M: begin
          if (c.action == pcr_pkg::CH_LO_M) begin
            px += a[0];
            py += a[1];
          end else begin
            px = a[0];
            py = a[1];
          end
          pen_x = px;
          pen_y = py;
          path_start_x = px;
          path_start_y = py;
          res.push_back(mk_prim(pcr_pkg::KIND_MOVE, px, py, '0, '0, '0, '0));
        end
        pcr_pkg::CH_UP_L, pcr_pkg::CH_LO_L, pcr_pkg::CH_UP_H, pcr_pkg::CH_LO_H,
        pcr_pkg::CH_UP_V, pcr_pkg::CH_LO_V: begin
          case (c.action)
            pcr_pkg::CH_UP_L: begin
              px = a[0];
              py = a[1];
            end
            pcr_pkg::CH_LO_L: begin
              px += a[0];
              py += a[1];
            end
            pcr_pkg::CH_UP_H: px = a[0];
            pcr_pkg::CH_LO_H: px += a[0];
            pcr_pkg::CH_UP_V: py = a[0];
            default: py += a[0];
          endcase
          pen_x = px;
          pen_y = py;
          res.push_back(mk_prim(pcr_pkg::KIND_LINE, px, py, '0, '0, '0, '0));
        end
        pcr_pkg::CH_UP_C, pcr_pkg::CH_LO_C: begin
          if (c.action == pcr_pkg::CH_LO_C) begin
            for (int i = 0; i < pcr_pkg::NUM_ARGS; i += 2) begin
              a[i]   += px;
              a[i+1] += py;
            end
          end
          ctl_x = a[2];
          ctl_y = a[3];
          pen_x = a[4];
          pen_y = a[5];
          res.push_back(mk_prim(pcr_pkg::KIND_CUBIC, a[0], a[1], a[2], a[3], a[4], a[5]));
        end
        pcr_pkg::CH_UP_S, pcr_pkg::CH_LO_S, pcr_pkg::CH_UP_Q, pcr_pkg::CH_LO_Q: begin
          if (c.action == pcr_pkg::CH_LO_S || c.action == pcr_pkg::CH_LO_Q) begin
            a[0] += px;
            a[1] += py;
            a[2] += px;
            a[3] += py;
          end
          ctl_x = a[0];
          ctl_y = a[1];
          pen_x = a[2];
          pen_y = a[3];
          if (c.action == pcr_pkg::CH_UP_S || c.action == pcr_pkg::CH_LO_S)
            res.push_back(mk_prim(pcr_pkg::KIND_CUBIC, rx, ry, a[0], a[1], a[2], a[3]));
          else
            res.push_back(mk_prim(pcr_pkg::KIND_QUAD, a[0], a[1], a[2], a[3], '0, '0));
        end
        pcr_pkg::CH_UP_T, pcr_pkg::CH_LO_T: begin
          if (c.action == pcr_pkg::CH_LO_T) begin
            a[0] += px;
            a[1] += py;
          end
          ctl_x = rx;
          ctl_y = ry;
          pen_x = a[0];
          pen_y = a[1];
          res.push_back(mk_prim(pcr_pkg::KIND_QUAD, rx, ry, a[0], a[1], '0, '0));
        end
        pcr_pkg::CH_UP_Z, pcr_pkg::CH_LO_Z: begin
          pen_x = path_start_x;
          pen_y = path_start_y;
          res.push_back(mk_prim(pcr_pkg::KIND_CLOSE, path_start_x, path_start_y,
                                '0, '0, '0, '0));
        end
        default: ;
      endcase
    end
    if (c.path_end) begin
      res.push_back(mk_prim(pcr_pkg::KIND_FILL, '0, '0, '0, '0, '0, '0));
      clear_pen();
    end
    if (res.size() > 0) begin
      tail = res.pop_back();
      tail.run_last = 1'b1;
      res.push_back(tail);
    end
    foreach (res[i]) pending_prims.push_back(res[i]);
  endfunction

  function automatic outline_cmd_t mk_cmd(input logic [7:0] act,
                                          input int a0, a1, a2, a3, a4, a5);
    outline_cmd_t c;
    c.action    = act;
    c.arg[0]    = a0[pcr_pkg::ARG_W-1:0];
    c.arg[1]    = a1[pcr_pkg::ARG_W-1:0];
    c.arg[2]    = a2[pcr_pkg::ARG_W-1:0];
    c.arg[3]    = a3[pcr_pkg::ARG_W-1:0];
    c.arg[4]    = a4[pcr_pkg::ARG_W-1:0];
    c.arg[5]    = a5[pcr_pkg::ARG_W-1:0];
    c.cmd_valid = 1'b1;
    c.path_end  = 1'b0;
    return c;
  endfunction

  function automatic outline_cmd_t rand_cmd(input logic [7:0] act);
    outline_cmd_t c;
    c.action = act;
    for (int i = 0; i < pcr_pkg::NUM_ARGS; i++) begin
      if ($urandom_range(0, 1))
        c.arg[i] = pcr_pkg::ARG_W'($urandom);
      else
        c.arg[i] = pcr_pkg::ARG_W'($urandom_range(0, 400) - 200);
    end
    c.cmd_valid = 1'b1;
    c.path_end  = ($urandom_range(0, 39) == 0);
    return c;
  endfunction

  task automatic send_cmd(input outline_cmd_t c);
    int gap;
    @(negedge clk);
    cmd_bus.action    = c.action;
    cmd_bus.arg0      = c.arg[0];
    cmd_bus.arg1      = c.arg[1];
    cmd_bus.arg2      = c.arg[2];
    cmd_bus.arg3      = c.arg[3];
    cmd_bus.arg4      = c.arg[4];
    cmd_bus.arg5      = c.arg[5];
    cmd_bus.cmd_valid = c.cmd_valid;
    cmd_bus.path_end  = c.path_end;
    cmd_bus.valid     = 1'b1;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    resolve_command(c);
    gap = tx_no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      cmd_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    while (pending_prims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    outline_cmd_t c;
    // the first smooth command right after reset reflects a zero control point
    send_cmd(mk_cmd(pcr_pkg::CH_UP_S, 1, 2, 3, 4, 77, -77));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_T, -32768, 32767, 5, 5, 5, 5));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_M, 32767, -32768, 1, 1, 1, 1));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_M, -32768, 32767, 0, 0, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_L, 100, 200, -1, -1, -1, -1));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_L, -1, -1, 0, 0, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_H, -32768, 9, 9, 9, 9, 9));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_H, 32767, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_V, 32767, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_V, -32768, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_C, 32767, -32768, -32768, 32767, 1, -1));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_C, -32768, -32768, -32768, -32768, -32768, -32768));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_S, 32767, 32767, 32767, 32767, 3, 3));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_Q, 10, -20, 30, -40, 5, 5));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_Q, -5, 6, -7, 8, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_T, 1234, -4321, 0, 0, 0, 0));
    // smooth cubic after a line still uses the stale control point
    send_cmd(mk_cmd(pcr_pkg::CH_UP_L, -300, 400, 0, 0, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_S, 50, 60, 70, 80, 0, 0));
    send_cmd(mk_cmd(pcr_pkg::CH_UP_Z, 11, 22, 33, 44, 55, 66));
    send_cmd(mk_cmd(pcr_pkg::CH_LO_Z, 0, 0, 0, 0, 0, 0));
    c = mk_cmd(pcr_pkg::CH_UP_L, 999, 999, 0, 0, 0, 0);
    c.cmd_valid = 1'b0;
    send_cmd(c);
    send_cmd(mk_cmd(CH_UNKNOWN_A, 1, 2, 3, 4, 5, 6));
    // path end with a primitive, with a skipped and with an unknown command
    c = mk_cmd(pcr_pkg::CH_UP_L, 7, 8, 0, 0, 0, 0);
    c.path_end = 1'b1;
    send_cmd(c);
    c = mk_cmd(pcr_pkg::CH_UP_M, 5, 5, 0, 0, 0, 0);
    c.cmd_valid = 1'b0;
    c.path_end  = 1'b1;
    send_cmd(c);
    c = mk_cmd(CH_UNKNOWN_FF, -1, -1, -1, -1, -1, -1);
    c.path_end = 1'b1;
    send_cmd(c);
    send_cmd(mk_cmd(pcr_pkg::CH_LO_T, 3, 4, 0, 0, 0, 0));
  endtask

  // receiver holds off long enough for the internal queue to fill
  task automatic test_backpressure();
    rx_hold    = 120;
    tx_no_idle = 1'b1;
    send_cmd(rand_cmd(pcr_pkg::CH_UP_M));
    repeat (24) send_cmd(rand_cmd(DRAW_LETTERS[$urandom_range(0, 15)]));
    tx_no_idle = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_paths(input int n_items);
    int sent;
    int len;
    int r;
    outline_cmd_t c;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_cmd(rand_cmd($urandom_range(0, 1) ? pcr_pkg::CH_UP_M : pcr_pkg::CH_LO_M));
        sent++;
      end
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        c = rand_cmd(DRAW_LETTERS[$urandom_range(0, 15)]);
        r = $urandom_range(0, 99);
        if (r < 5)
          c.cmd_valid = 1'b0;
        else if (r < 10)
          c.action = 8'($urandom_range(0, 255));
        if (i == len - 1 && $urandom_range(0, 3) != 0)
          c.path_end = 1'b1;
        send_cmd(c);
        sent++;
      end
    end
  endtask

  // relative steps carry x far up and y far down before random lines and curves follow
  task automatic test_long_relative_run();
    outline_cmd_t c;
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    send_cmd(mk_cmd(pcr_pkg::CH_UP_M, 0, 0, 0, 0, 0, 0));
    repeat (RUN_STEPS) send_cmd(mk_cmd(pcr_pkg::CH_LO_L, 32767, -32768, 0, 0, 0, 0));
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    repeat (20) begin
      c = rand_cmd(DRAW_LETTERS[$urandom_range(0, 13)]);
      c.path_end = 1'b0;
      send_cmd(c);
    end
    c = mk_cmd(pcr_pkg::CH_UP_Z, 0, 0, 0, 0, 0, 0);
    c.path_end = 1'b1;
    send_cmd(c);
  endtask

  task automatic compare_field(input string name,
                               input logic [pcr_pkg::COORD_W-1:0] want,
                               input logic [pcr_pkg::COORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    primitive_t want;
    if (!rst && prim_bus.valid === 1'b1 && prim_bus.ready === 1'b1) begin
      if (pending_prims.size() == 0) begin
        $error("primitive with nothing expected: kind %0d", prim_bus.kind);
        fail_count++;
      end else begin
        want = pending_prims.pop_front();
        compare_field("kind", pcr_pkg::COORD_W'(want.kind),
                      pcr_pkg::COORD_W'(prim_bus.kind));
        compare_field("pt1_x", want.pt1_x, prim_bus.pt1_x);
        compare_field("pt1_y", want.pt1_y, prim_bus.pt1_y);
        compare_field("pt2_x", want.pt2_x, prim_bus.pt2_x);
        compare_field("pt2_y", want.pt2_y, prim_bus.pt2_y);
        compare_field("pt3_x", want.pt3_x, prim_bus.pt3_x);
        compare_field("pt3_y", want.pt3_y, prim_bus.pt3_y);
        compare_field("run_last", pcr_pkg::COORD_W'(want.run_last),
                      pcr_pkg::COORD_W'(prim_bus.run_last));
      end
    end
  end

  initial begin
    prim_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        prim_bus.ready = 1'b0;
        rx_hold--;
      end else if (rx_no_idle) begin
        prim_bus.ready = 1'b1;
      end else if (rx_stall > 0) begin
        prim_bus.ready = 1'b0;
        rx_stall--;
      end else begin
        prim_bus.ready = 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_path_command_resolver NOT OK");
      $finish;
    end
  end

  initial begin
    cmd_bus.valid     = 1'b0;
    cmd_bus.action    = '0;
    cmd_bus.arg0      = '0;
    cmd_bus.arg1      = '0;
    cmd_bus.arg2      = '0;
    cmd_bus.arg3      = '0;
    cmd_bus.arg4      = '0;
    cmd_bus.arg5      = '0;
    cmd_bus.cmd_valid = 1'b0;
    cmd_bus.path_end  = 1'b0;
    clear_pen();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    wait_drain();
    test_backpressure();
    test_random_paths(250);
    test_long_relative_run();
    test_random_paths(250);
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    wait_drain();

    if (fail_count == 0)
      $display("tb_path_command_resolver OK");
    else
      $display("tb_path_command_resolver NOT OK");
    $finish;
  end

endmodule
